// File: sv/nfsa_pkg.sv
// Shared types and constants for the next-fit segment allocator.
package nfsa_pkg;
  localparam int unsigned MaxSeg   = 64;
  localparam int unsigned SlotW    = $clog2(MaxSeg);
  localparam int unsigned LinkW    = SlotW + 1;
  localparam int unsigned UnitBits = 24;
  localparam int unsigned SizeW    = UnitBits + 1;
  localparam int unsigned CfgW     = 25;
  localparam int unsigned StepW    = $clog2(MaxSeg + 1);
  localparam logic [LinkW-1:0] NilLink = LinkW'(MaxSeg);
  localparam logic [SizeW-1:0] CapMax  = SizeW'(1) << UnitBits;
  localparam logic [SizeW-1:0] CapRst  = SizeW'(65536);

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoSpace = 2'd1;
  localparam logic [1:0] StBadBase = 2'd2;
  localparam logic [1:0] StFull    = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_CHK, S_SPLIT, S_FREE, S_MPREV, S_MPREV2, S_MNEXT, S_MNEXT2,
    S_DONE, S_OUT
  } state_e;

  typedef struct packed {
    logic load;      // capture input item, set walk pointer
    logic rd;        // read entry at walk pointer
    logic adv;       // advance walk pointer to next link
    logic split;     // perform split write
    logic exact;     // mark current used
    logic free_cur;  // mark current free, begin merge
    logic mrg_prev;  // merge with previous
    logic mrg_prev2; // relink around previous
    logic mrg_next;  // merge with next
    logic mrg_next2; // relink around next
    logic fin_free;  // cursor to head, ok result
    logic nospace;   // cursor to head, no space result
    logic err;       // error result with given status
    logic [1:0] err_st;
  } cmd_t;

  typedef struct packed {
    logic is_free;
    logic zero_size;
    logic at_end;     // walk pointer nil or step limit
    logic hit;        // current entry satisfies search
    logic exact;
    logic cur_used;   // current entry is in use
    logic vac_any;
    logic prev_free;  // previous exists and is free
    logic next_free;
    logic out_busy;
  } stat_t;
endpackage

// File: sv/next_fit_segment_allocator.sv
// Next-fit segment allocator: one item at a time; walk reads and checks each entry.
// The next item is accepted after the output state, unless the result is stalled.
// Reset or a capacity write restores one free segment covering the heap;
// slot zero is rebuilt on its first edit.
module next_fit_segment_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nfsa_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          func_i,
  input  logic [nfsa_pkg::SizeW-1:0]    alloc_size_i,
  input  logic [nfsa_pkg::UnitBits-1:0] free_base_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [nfsa_pkg::UnitBits-1:0] region_base_o,
  output logic [nfsa_pkg::SizeW-1:0]    region_size_o
);
  nfsa_pkg::cmd_t  cmd;
  nfsa_pkg::stat_t stat;

  nfsa_ctrl u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .in_valid_i, .in_stall_o,
    .stat_i(stat), .cmd_o(cmd)
  );

  nfsa_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .func_i, .alloc_size_i,
    .free_base_i, .out_stall_i, .out_valid_o, .status_o, .region_base_o,
    .region_size_o, .cmd_i(cmd), .stat_o(stat)
  );
endmodule

// File: sv/nfsa_ctrl.sv
// Controller state machine for the allocator.
module nfsa_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  nfsa_pkg::stat_t stat_i,
  output nfsa_pkg::cmd_t  cmd_o
);
  nfsa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= nfsa_pkg::S_IDLE;
    else if (cfg_we_i) state_q <= nfsa_pkg::S_IDLE;
    else state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    case (state_q)
      nfsa_pkg::S_IDLE: begin
        in_stall_o = stat_i.out_busy;
        if (in_valid_i && !stat_i.out_busy) begin
          cmd_o.load = 1'b1;
          state_d = nfsa_pkg::S_RD;
        end
      end
      nfsa_pkg::S_RD: begin
        if (stat_i.is_free) begin
          cmd_o.rd = 1'b1;
          state_d = nfsa_pkg::S_CHK;
        end else if (stat_i.zero_size) begin
          cmd_o.err = 1'b1;
          cmd_o.err_st = nfsa_pkg::StNoSpace;
          state_d = nfsa_pkg::S_OUT;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = nfsa_pkg::S_CHK;
        end
        if (stat_i.at_end) begin
          cmd_o.rd = 1'b0;
          cmd_o.err = 1'b1;
          if (stat_i.is_free) cmd_o.err_st = nfsa_pkg::StBadBase;
          else begin
            cmd_o.err_st = nfsa_pkg::StNoSpace;
            cmd_o.nospace = ~stat_i.zero_size;
          end
          state_d = nfsa_pkg::S_OUT;
        end
      end
      nfsa_pkg::S_CHK: begin
        if (stat_i.hit) begin
          if (stat_i.is_free) begin
            // a matched base on a free segment is an error item
            if (stat_i.cur_used) state_d = nfsa_pkg::S_FREE;
            else begin
              cmd_o.err = 1'b1;
              cmd_o.err_st = nfsa_pkg::StBadBase;
              state_d = nfsa_pkg::S_OUT;
            end
          end else if (stat_i.exact) begin
            cmd_o.exact = 1'b1;
            state_d = nfsa_pkg::S_OUT;
          end else if (!stat_i.vac_any) begin
            cmd_o.err = 1'b1;
            cmd_o.err_st = nfsa_pkg::StFull;
            state_d = nfsa_pkg::S_OUT;
          end else state_d = nfsa_pkg::S_SPLIT;
        end else begin
          cmd_o.adv = 1'b1;
          state_d = nfsa_pkg::S_RD;
        end
      end
      nfsa_pkg::S_SPLIT: begin
        cmd_o.split = 1'b1;
        state_d = nfsa_pkg::S_OUT;
      end
      nfsa_pkg::S_FREE: begin
        cmd_o.free_cur = 1'b1;
        state_d = nfsa_pkg::S_MPREV;
      end
      nfsa_pkg::S_MPREV: begin
        if (stat_i.prev_free) begin
          cmd_o.mrg_prev = 1'b1;
          state_d = nfsa_pkg::S_MPREV2;
        end else state_d = nfsa_pkg::S_MNEXT;
      end
      nfsa_pkg::S_MPREV2: begin
        cmd_o.mrg_prev2 = 1'b1;
        state_d = nfsa_pkg::S_MNEXT;
      end
      nfsa_pkg::S_MNEXT: begin
        if (stat_i.next_free) begin
          cmd_o.mrg_next = 1'b1;
          state_d = nfsa_pkg::S_MNEXT2;
        end else state_d = nfsa_pkg::S_DONE;
      end
      nfsa_pkg::S_MNEXT2: begin
        cmd_o.mrg_next2 = 1'b1;
        state_d = nfsa_pkg::S_DONE;
      end
      nfsa_pkg::S_DONE: begin
        cmd_o.fin_free = 1'b1;
        state_d = nfsa_pkg::S_OUT;
      end
      nfsa_pkg::S_OUT: state_d = nfsa_pkg::S_IDLE;
      default: state_d = nfsa_pkg::S_IDLE;
    endcase
  end
endmodule

// File: sv/nfsa_dp.sv
// Datapath: segment store, walk pointer, list edits and result register.
module nfsa_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nfsa_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          func_i,
  input  logic [nfsa_pkg::SizeW-1:0]    alloc_size_i,
  input  logic [nfsa_pkg::UnitBits-1:0] free_base_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [1:0]                    status_o,
  output logic [nfsa_pkg::UnitBits-1:0] region_base_o,
  output logic [nfsa_pkg::SizeW-1:0]    region_size_o,
  input  nfsa_pkg::cmd_t                cmd_i,
  output nfsa_pkg::stat_t               stat_o
);
  localparam int unsigned SW = nfsa_pkg::SlotW;
  localparam int unsigned LW = nfsa_pkg::LinkW;
  localparam int unsigned UW = nfsa_pkg::UnitBits;
  localparam int unsigned ZW = nfsa_pkg::SizeW;
  localparam int unsigned N  = nfsa_pkg::MaxSeg;

  // Segment store; start/length/links are only read on listed slots.
  logic [UW-1:0] start_m [N];
  logic [ZW-1:0] len_m   [N];
  logic [LW-1:0] next_m  [N];
  logic [LW-1:0] prev_m  [N];
  logic [N-1:0]  used_q, vac_q;
  logic [SW-1:0] head_q;
  logic [LW-1:0] cursor_q;
  logic          init_q;   // slot zero needs rebuilding on next edit
  logic [ZW-1:0] cap_q;

  logic          func_q;
  logic [ZW-1:0] size_q;
  logic [UW-1:0] base_q;
  logic [LW-1:0] walk_q;
  logic [nfsa_pkg::StepW-1:0] steps_q;
  // registered read of current entry
  logic [UW-1:0] r_start_q;
  logic [ZW-1:0] r_len_q;
  logic [LW-1:0] r_next_q, r_prev_q;
  // neighbor data for merges
  logic [UW-1:0] n_start_q;
  logic [ZW-1:0] n_len_q;
  logic [LW-1:0] n_link_q;
  logic [ZW-1:0] acc_len_q;
  logic [LW-1:0] acc_prev_q, acc_next_q;

  logic out_v_q;
  logic [1:0] st_q;
  logic [UW-1:0] ob_q;
  logic [ZW-1:0] os_q;

  logic [SW-1:0] cur, fresh;
  logic vac_any;
  assign cur = walk_q[SW-1:0];

  always_comb begin
    fresh = '0;
    vac_any = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (vac_q[i]) begin
        fresh = SW'(i);
        vac_any = 1'b1;
      end
    end
  end

  logic [UW-1:0] rs;
  logic [ZW-1:0] rl;
  logic [LW-1:0] rn, rp;
  // slot zero after a rebuild reads as the whole heap
  assign rs = (init_q && cur == '0) ? '0 : r_start_q;
  assign rl = (init_q && cur == '0) ? cap_q : r_len_q;
  assign rn = (init_q && cur == '0) ? nfsa_pkg::NilLink : r_next_q;
  assign rp = (init_q && cur == '0) ? nfsa_pkg::NilLink : r_prev_q;

  logic [ZW-1:0] cap_sat;
  assign cap_sat = (cfg_data_i > nfsa_pkg::CapMax) ? nfsa_pkg::CapMax : cfg_data_i;

  logic [SW-1:0] pslot, nslot;
  assign pslot = acc_prev_q[SW-1:0];
  assign nslot = acc_next_q[SW-1:0];

  always_comb begin
    stat_o = '0;
    stat_o.is_free   = func_q;
    stat_o.zero_size = (size_q == '0);
    stat_o.at_end    = (walk_q >= nfsa_pkg::NilLink) || (steps_q >= nfsa_pkg::StepW'(N));
    stat_o.hit       = func_q ? (rs == base_q) : (!used_q[cur] && rl >= size_q);
    stat_o.exact     = (rl == size_q);
    stat_o.cur_used  = used_q[cur];
    stat_o.vac_any   = vac_any;
    stat_o.prev_free = (acc_prev_q < nfsa_pkg::NilLink) && !used_q[pslot];
    stat_o.next_free = (acc_next_q < nfsa_pkg::NilLink) && !used_q[nslot];
    stat_o.out_busy  = out_v_q && out_stall_i;
  end

  // Memory reads and writes; the slot-zero rebuild happens lazily on first write.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd) begin
      r_start_q <= start_m[cur];
      r_len_q   <= len_m[cur];
      r_next_q  <= next_m[cur];
      r_prev_q  <= prev_m[cur];
    end
    if (cmd_i.split) begin
      start_m[fresh] <= rs;
      len_m[fresh]   <= size_q;
      prev_m[fresh]  <= rp;
      next_m[fresh]  <= walk_q;
      start_m[cur]   <= rs + size_q[UW-1:0];
      len_m[cur]     <= rl - size_q;
      next_m[cur]    <= rn;
      prev_m[cur]    <= LW'(fresh);
      // relink the previous entry to the new used segment
      if (rp < nfsa_pkg::NilLink) next_m[rp[SW-1:0]] <= LW'(fresh);
    end
    if (cmd_i.exact || cmd_i.free_cur) begin
      start_m[cur] <= rs;
      len_m[cur]   <= rl;
      next_m[cur]  <= rn;
      prev_m[cur]  <= rp;
    end
    if (cmd_i.mrg_prev || cmd_i.mrg_next) begin
      n_start_q <= start_m[cmd_i.mrg_prev ? pslot : nslot];
      n_len_q   <= len_m[cmd_i.mrg_prev ? pslot : nslot];
      n_link_q  <= cmd_i.mrg_prev ? prev_m[pslot] : next_m[nslot];
    end
    if (cmd_i.mrg_prev2) begin
      start_m[cur] <= n_start_q;
      len_m[cur]   <= acc_len_q + n_len_q;
      prev_m[cur]  <= n_link_q;
      if (n_link_q < nfsa_pkg::NilLink) next_m[n_link_q[SW-1:0]] <= walk_q;
    end
    if (cmd_i.mrg_next2) begin
      len_m[cur]  <= acc_len_q + n_len_q;
      next_m[cur] <= n_link_q;
      if (n_link_q < nfsa_pkg::NilLink) prev_m[n_link_q[SW-1:0]] <= walk_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      size_q <= alloc_size_i;
      base_q <= free_base_i;
    end
    if (cmd_i.free_cur) begin
      acc_len_q  <= rl;
      acc_prev_q <= rp;
      acc_next_q <= rn;
    end
    if (cmd_i.mrg_prev2) begin
      acc_len_q <= acc_len_q + n_len_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      vac_q    <= {{(N-1){1'b1}}, 1'b0};
      head_q   <= '0;
      cursor_q <= '0;
      init_q   <= 1'b1;
      cap_q    <= nfsa_pkg::CapRst;
      walk_q   <= '0;
      steps_q  <= '0;
      out_v_q  <= 1'b0;
      st_q     <= nfsa_pkg::StOk;
      ob_q     <= '0;
      os_q     <= '0;
    end else if (cfg_we_i) begin
      used_q   <= '0;
      vac_q    <= {{(N-1){1'b1}}, 1'b0};
      head_q   <= '0;
      cursor_q <= '0;
      init_q   <= 1'b1;
      cap_q    <= cap_sat;
    end else begin
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      if (cmd_i.load) begin
        walk_q  <= func_i ? LW'(head_q) : cursor_q;
        steps_q <= '0;
      end
      if (cmd_i.adv) begin
        walk_q  <= rn;
        steps_q <= steps_q + 1'b1;
      end
      if (cmd_i.exact || cmd_i.split || cmd_i.free_cur) init_q <= 1'b0;
      if (cmd_i.exact) begin
        used_q[cur] <= 1'b1;
        cursor_q    <= walk_q;
        out_v_q <= 1'b1; st_q <= nfsa_pkg::StOk; ob_q <= rs; os_q <= size_q;
      end
      if (cmd_i.split) begin
        used_q[fresh] <= 1'b1;
        vac_q[fresh]  <= 1'b0;
        cursor_q      <= walk_q;
        if (head_q == cur) head_q <= fresh;
        out_v_q <= 1'b1; st_q <= nfsa_pkg::StOk; ob_q <= rs; os_q <= size_q;
      end
      if (cmd_i.err) begin
        out_v_q <= 1'b1; st_q <= cmd_i.err_st; ob_q <= '0; os_q <= '0;
        if (cmd_i.err_st == nfsa_pkg::StFull) cursor_q <= walk_q;
        if (cmd_i.nospace) cursor_q <= LW'(head_q);
      end
      if (cmd_i.free_cur) begin
        used_q[cur] <= 1'b0;
        os_q <= rl;
      end
      if (cmd_i.mrg_prev2) begin
        vac_q[pslot] <= 1'b1;
        if (head_q == pslot) head_q <= cur;
      end
      if (cmd_i.mrg_next2) vac_q[nslot] <= 1'b1;
      if (cmd_i.fin_free) begin
        cursor_q <= LW'(head_q);
        out_v_q <= 1'b1; st_q <= nfsa_pkg::StOk; ob_q <= base_q;
      end
    end
  end

  assign out_valid_o   = out_v_q;
  assign status_o      = st_q;
  assign region_base_o = ob_q;
  assign region_size_o = os_q;
endmodule

// File: verif/next_fit_segment_allocator_checker.sv
// Checker for the next-fit segment allocator: segment list model and result compare.
`timescale 1ns / 100ps
module next_fit_segment_allocator_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [nfsa_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          func_i,
  input  logic [nfsa_pkg::SizeW-1:0]    alloc_size_i,
  input  logic [nfsa_pkg::UnitBits-1:0] free_base_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [1:0]                    status_i,
  input  logic [nfsa_pkg::UnitBits-1:0] region_base_i,
  input  logic [nfsa_pkg::SizeW-1:0]    region_size_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            results_seen_o
);

  typedef struct packed {
    logic [1:0]                    st;
    logic [nfsa_pkg::UnitBits-1:0] base;
    logic [nfsa_pkg::SizeW-1:0]    size;
  } grant_t;

  grant_t grant_q[$];

  logic [nfsa_pkg::SizeW-1:0]    capacity;
  logic [nfsa_pkg::UnitBits-1:0] seg_base[nfsa_pkg::MaxSeg];
  logic [nfsa_pkg::SizeW-1:0]    seg_len[nfsa_pkg::MaxSeg];
  logic                          seg_used[nfsa_pkg::MaxSeg];
  int                            seg_nxt[nfsa_pkg::MaxSeg];
  int                            seg_prv[nfsa_pkg::MaxSeg];
  logic                          slot_free[nfsa_pkg::MaxSeg];
  int                            head;
  int                            cursor;

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  function automatic void init_heap();
    for (int i = 0; i < nfsa_pkg::MaxSeg; i++) begin
      seg_base[i] = '0; seg_len[i] = '0; seg_used[i] = 1'b0;
      seg_nxt[i] = nfsa_pkg::MaxSeg; seg_prv[i] = nfsa_pkg::MaxSeg; slot_free[i] = 1'b1;
    end
    slot_free[0] = 1'b0;
    seg_len[0] = capacity;
    head = 0;
    cursor = 0;
  endfunction

  function automatic void drop_slot(int s);
    slot_free[s] = 1'b1; seg_used[s] = 1'b0;
    seg_nxt[s] = nfsa_pkg::MaxSeg; seg_prv[s] = nfsa_pkg::MaxSeg;
  endfunction

  function automatic grant_t grant_alloc(logic [nfsa_pkg::SizeW-1:0] size);
    int cur, steps, fresh, p;
    grant_t g;
    cur = cursor;
    steps = 0;
    fresh = nfsa_pkg::MaxSeg;
    g = '{st: nfsa_pkg::StNoSpace, base: '0, size: '0};
    if (size == 0) return g;
    while (cur < nfsa_pkg::MaxSeg && steps < nfsa_pkg::MaxSeg) begin
      if (!seg_used[cur] && seg_len[cur] >= size) break;
      cur = seg_nxt[cur];
      steps++;
    end
    if (cur >= nfsa_pkg::MaxSeg || steps >= nfsa_pkg::MaxSeg) begin
      cursor = head;
      return g;
    end
    cursor = cur;
    if (seg_len[cur] == size) begin
      seg_used[cur] = 1'b1;
      return '{st: nfsa_pkg::StOk, base: seg_base[cur], size: size};
    end
    for (int i = nfsa_pkg::MaxSeg - 1; i >= 0; i--) if (slot_free[i]) fresh = i;
    if (fresh >= nfsa_pkg::MaxSeg) return '{st: nfsa_pkg::StFull, base: '0, size: '0};
    p = seg_prv[cur];
    slot_free[fresh] = 1'b0;
    seg_base[fresh] = seg_base[cur];
    seg_len[fresh] = size;
    seg_used[fresh] = 1'b1;
    seg_prv[fresh] = p;
    seg_nxt[fresh] = cur;
    if (p < nfsa_pkg::MaxSeg) seg_nxt[p] = fresh;
    seg_prv[cur] = fresh;
    seg_base[cur] = seg_base[cur] + nfsa_pkg::UnitBits'(size);
    seg_len[cur] = seg_len[cur] - size;
    if (head == cur) head = fresh;
    return '{st: nfsa_pkg::StOk, base: seg_base[fresh], size: size};
  endfunction

  function automatic grant_t grant_free(logic [nfsa_pkg::UnitBits-1:0] base);
    int cur, steps, p, n;
    logic [nfsa_pkg::SizeW-1:0] freed;
    cur = head;
    steps = 0;
    while (cur < nfsa_pkg::MaxSeg && steps < nfsa_pkg::MaxSeg) begin
      if (seg_base[cur] == base) break;
      cur = seg_nxt[cur];
      steps++;
    end
    if (cur >= nfsa_pkg::MaxSeg || steps >= nfsa_pkg::MaxSeg || !seg_used[cur])
      return '{st: nfsa_pkg::StBadBase, base: '0, size: '0};
    freed = seg_len[cur];
    seg_used[cur] = 1'b0;
    p = seg_prv[cur];
    n = seg_nxt[cur];
    if (p < nfsa_pkg::MaxSeg && !seg_used[p]) begin
      seg_base[cur] = seg_base[p];
      seg_len[cur] = seg_len[cur] + seg_len[p];
      if (head == p) head = cur;
      seg_prv[cur] = seg_prv[p];
      if (seg_prv[cur] < nfsa_pkg::MaxSeg) seg_nxt[seg_prv[cur]] = cur;
      drop_slot(p);
    end
    if (n < nfsa_pkg::MaxSeg && !seg_used[n]) begin
      seg_len[cur] = seg_len[cur] + seg_len[n];
      seg_nxt[cur] = seg_nxt[n];
      if (seg_nxt[cur] < nfsa_pkg::MaxSeg) seg_prv[seg_nxt[cur]] = cur;
      drop_slot(n);
    end
    cursor = head;
    return '{st: nfsa_pkg::StOk, base: base, size: freed};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t g;
    if (!rst_ni) begin
      capacity = nfsa_pkg::CapRst;
      init_heap();
      grant_q.delete();
      fail_count_o = 0;
      results_seen_o = 0;
    end else begin
      if (cfg_we_i) begin
        capacity = (cfg_data_i > nfsa_pkg::CapMax) ? nfsa_pkg::CapMax : cfg_data_i;
        init_heap();
      end
      if (out_valid_i && !out_stall_i) begin
        results_seen_o++;
        if (grant_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          g = grant_q.pop_front();
          if (status_i !== g.st)
            report_mismatch($sformatf("status %0d, want %0d", status_i, g.st));
          if (region_base_i !== g.base)
            report_mismatch($sformatf("base %0h, want %0h", region_base_i, g.base));
          if (region_size_i !== g.size)
            report_mismatch($sformatf("size %0h, want %0h", region_size_i, g.size));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (func_i) g = grant_free(free_base_i);
        else g = grant_alloc(alloc_size_i);
        grant_q.push_back(g);
      end
    end
    pending_o = grant_q.size();
  end

endmodule

// File: verif/next_fit_segment_allocator_tb.sv
// Testbench top for the next-fit segment allocator: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module next_fit_segment_allocator_tb;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [nfsa_pkg::CfgW-1:0]     cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic                          func_i = 1'b0;
  logic [nfsa_pkg::SizeW-1:0]    alloc_size_i = '0;
  logic [nfsa_pkg::UnitBits-1:0] free_base_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [1:0]                    status_o;
  logic [nfsa_pkg::UnitBits-1:0] region_base_o;
  logic [nfsa_pkg::SizeW-1:0]    region_size_o;
  int                            fail_count, pending, results_seen;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_off = 0;
  logic [nfsa_pkg::UnitBits-1:0] live_bases[$];
  logic                          sent_fns[$];
  logic [nfsa_pkg::SizeW-1:0]    size_cap = nfsa_pkg::SizeW'(65536);
  int items_sent = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  next_fit_segment_allocator dut (.*);

  next_fit_segment_allocator_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .in_valid_i,
    .in_stall_i(in_stall_o), .func_i, .alloc_size_i, .free_base_i,
    .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .region_base_i(region_base_o), .region_size_i(region_size_o),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  // Receiver flow control; a hold-off forces a long stall.
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_stall_i <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Track granted bases so frees mostly hit live regions.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i && sent_fns.size() > 0) begin
      if (!sent_fns.pop_front() && status_o == nfsa_pkg::StOk)
        live_bases.push_back(region_base_o);
    end
  end

  task automatic send_item(input logic fn, input logic [nfsa_pkg::SizeW-1:0] sz,
                           input logic [nfsa_pkg::UnitBits-1:0] base);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= fn;
    alloc_size_i <= sz;
    free_base_i <= base;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent_fns.push_back(fn);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending > 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [nfsa_pkg::CfgW-1:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    size_cap = (v > nfsa_pkg::CapMax) ? nfsa_pkg::CapMax : v;
    live_bases.delete();
  endtask

  task automatic random_item();
    logic [nfsa_pkg::SizeW-1:0] sz;
    int r;
    r = $urandom_range(99);
    if (r < 55 || live_bases.size() == 0) begin
      if ($urandom_range(9) == 0)
        sz = nfsa_pkg::SizeW'($urandom_range(size_cap > 0 ? size_cap : 1, 0));
      else sz = nfsa_pkg::SizeW'($urandom_range(size_cap / 40 + 1, 1));
      if ($urandom_range(49) == 0) sz = nfsa_pkg::SizeW'($urandom);
      send_item(1'b0, sz, nfsa_pkg::UnitBits'($urandom));
    end else if (r < 92) begin
      int k;
      k = $urandom_range(live_bases.size() - 1);
      send_item(1'b1, nfsa_pkg::SizeW'($urandom), live_bases[k]);
      live_bases.delete(k);
    end else begin
      send_item(1'b1, nfsa_pkg::SizeW'($urandom), nfsa_pkg::UnitBits'($urandom));
    end
  endtask

  task automatic random_phase(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (n) random_item();
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // Directed: reset capacity, zero size, exact fit, no fit, bad base, merges.
    send_item(1'b0, '0, '0);
    send_item(1'b0, 25'd65537, '0);
    send_item(1'b0, 25'd100, '0);
    send_item(1'b0, 25'd200, '0);
    send_item(1'b0, 25'd300, '0);
    send_item(1'b1, '0, 24'd100);
    send_item(1'b1, '0, 24'd100);
    send_item(1'b1, '0, 24'd5);
    send_item(1'b1, '0, 24'd0);
    send_item(1'b1, '0, 24'd300);
    send_item(1'b0, 25'd65536, '0);
    send_item(1'b1, '0, 24'hFFFFFF);
    send_item(1'b0, 25'h1FFFFFF, '0);
    write_capacity('0);
    send_item(1'b0, 25'd1, '0);
    write_capacity(25'h1FFFFFF);
    send_item(1'b0, 25'h1000000, '0);
    send_item(1'b1, '0, 24'd0);
    write_capacity(25'd3);
    send_item(1'b0, 25'd3, '0);
    send_item(1'b1, '0, 24'd0);
    // Store full: many unit allocations.
    write_capacity(25'd80);
    repeat (70) send_item(1'b0, 25'd1, '0);
    send_item(1'b1, '0, 24'd3);
    send_item(1'b1, '0, 24'd4);
    write_capacity(25'd1);
    send_item(1'b0, 25'd1, '0);
    write_capacity(25'd4096);
    random_phase(100, 0, 0);
    write_capacity(25'd65536);
    random_phase(100, 55, 0);
    hold_off = 400;
    random_phase(40, 0, 0);
    write_capacity(25'd300);
    random_phase(100, 0, 55);
    write_capacity(25'h1000000);
    random_phase(110, 10, 10);
    drain();
    $display("Covered %0d items, %0d results, capacities from zero to full range.",
             items_sent, results_seen);
    $display("Flow control phases: free running, sender gaps, receiver stalls, hold-off.");
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
